// ----- rtl/pcaw_pkg.sv -----
// Package: shared types, widths and register codes for the PI controller block.
package pcaw_pkg;

    localparam int DATA_W     = 16;
    localparam int GAIN_W     = 32;
    localparam int INTEG_W    = 32;
    localparam int FRAC_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int IN_TDATA_W = 3 * DATA_W;

    localparam logic signed [GAIN_W-1:0]  PROP_GAIN_RST    = 32'sd65536;
    localparam logic signed [GAIN_W-1:0]  INTEG_GAIN_RST   = 32'sd0;
    localparam logic signed [DATA_W-1:0]  DRIVE_LIM_RST    = 16'sd32767;
    // largest integrator magnitude: 32767 * 65536
    localparam logic signed [INTEG_W-1:0] INTEG_MAX        = 32'sd2147418112;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROP_GAIN    = 2'd0,
        CFG_INTEG_GAIN   = 2'd1,
        CFG_DRIVE_LIM    = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic signed [GAIN_W-1:0] prop_gain;
        logic signed [GAIN_W-1:0] integ_gain;
        logic signed [DATA_W-1:0] drive_lim;
    } t_cfg;

    typedef struct packed {
        logic signed [DATA_W-1:0]  drive;
        logic                      saturated;
        logic                      integ_we;
        logic signed [INTEG_W-1:0] integ_next;
    } t_step_res;

endpackage

// ----- rtl/pcaw_cfg_regs.sv -----
// Configuration registers: gains and output limit, written through a plain write port.
module pcaw_cfg_regs
    import pcaw_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prop_gain  <= PROP_GAIN_RST;
            r_cfg.integ_gain <= INTEG_GAIN_RST;
            r_cfg.drive_lim  <= DRIVE_LIM_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_PROP_GAIN:  r_cfg.prop_gain  <= i_cfg_data;
                CFG_INTEG_GAIN: r_cfg.integ_gain <= i_cfg_data;
                CFG_DRIVE_LIM:  r_cfg.drive_lim  <= i_cfg_data[DATA_W-1:0];
                default: ; // unused index, write dropped
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/pcaw_step.sv -----
// One PI step: error, proportional term, clamped integrator candidate, anti-windup, saturation.
module pcaw_step
    import pcaw_pkg::*;
(
    input  t_cfg                      i_cfg,
    input  logic signed [DATA_W-1:0]  i_reference,
    input  logic signed [DATA_W-1:0]  i_feedback,
    input  logic signed [DATA_W-1:0]  i_ff_term,
    input  logic signed [INTEG_W-1:0] i_integ,
    output t_step_res                 o_res
);

    localparam int ERR_W  = DATA_W + 1;
    localparam int PROD_W = ERR_W + GAIN_W;
    localparam int PROP_W = PROD_W - FRAC_W;
    localparam int CAND_W = PROD_W + 1;
    localparam int QUO_W  = INTEG_W - FRAC_W + 1;
    localparam int SUM_W  = PROP_W + 2;

    logic signed [ERR_W-1:0]   err;
    logic signed [PROD_W-1:0]  prod_p;
    logic signed [PROD_W-1:0]  prod_i;
    logic signed [PROP_W-1:0]  prop;
    logic signed [CAND_W-1:0]  cand_raw;
    logic signed [CAND_W-1:0]  bound_w;
    logic signed [INTEG_W-1:0] bound;
    logic signed [INTEG_W-1:0] cand;
    logic signed [QUO_W-1:0]   cand_q;
    logic signed [QUO_W-1:0]   integ_q;
    logic signed [SUM_W-1:0]   ff_w;
    logic signed [SUM_W-1:0]   lim_w;
    logic signed [SUM_W-1:0]   y_cand;
    logic signed [SUM_W-1:0]   y_keep;
    logic signed [SUM_W-1:0]   y_out;
    logic                      active;
    logic                      refuse;

    always_comb begin
        active = !i_cfg.drive_lim[DATA_W-1] && (i_cfg.drive_lim != '0);
        err    = {i_reference[DATA_W-1], i_reference}
               - {i_feedback[DATA_W-1], i_feedback};

        prod_p = PROD_W'(err) * PROD_W'(i_cfg.prop_gain);
        prod_i = PROD_W'(err) * PROD_W'(i_cfg.integ_gain);

        // divide by 2^16, rounding toward zero
        prop = prod_p[PROD_W-1:FRAC_W]
             + {{(PROP_W-1){1'b0}}, (prod_p[PROD_W-1] && (prod_p[FRAC_W-1:0] != '0))};

        bound    = {i_cfg.drive_lim, {FRAC_W{1'b0}}};
        bound_w  = {{(CAND_W-INTEG_W){1'b0}}, bound};
        cand_raw = {{(CAND_W-INTEG_W){i_integ[INTEG_W-1]}}, i_integ}
                 + {prod_i[PROD_W-1], prod_i};
        if (cand_raw > bound_w)
            cand = bound;
        else if (cand_raw < -bound_w)
            cand = -bound;
        else
            cand = cand_raw[INTEG_W-1:0];

        cand_q  = {cand[INTEG_W-1], cand[INTEG_W-1:FRAC_W]}
                + {{(QUO_W-1){1'b0}}, (cand[INTEG_W-1] && (cand[FRAC_W-1:0] != '0))};
        integ_q = {i_integ[INTEG_W-1], i_integ[INTEG_W-1:FRAC_W]}
                + {{(QUO_W-1){1'b0}},
                   (i_integ[INTEG_W-1] && (i_integ[FRAC_W-1:0] != '0))};

        ff_w   = {{(SUM_W-DATA_W){i_ff_term[DATA_W-1]}}, i_ff_term};
        lim_w  = {{(SUM_W-DATA_W){1'b0}}, i_cfg.drive_lim};
        y_cand = {{(SUM_W-PROP_W){prop[PROP_W-1]}}, prop}
               + {{(SUM_W-QUO_W){cand_q[QUO_W-1]}}, cand_q} + ff_w;
        y_keep = {{(SUM_W-PROP_W){prop[PROP_W-1]}}, prop}
               + {{(SUM_W-QUO_W){integ_q[QUO_W-1]}}, integ_q} + ff_w;

        // conditional integration: hold when beyond the limit and error drives further out
        refuse = ((y_cand > lim_w) && !err[ERR_W-1] && (err != '0))
              || ((y_cand < -lim_w) && err[ERR_W-1]);
        y_out  = refuse ? y_keep : y_cand;

        o_res.integ_next = cand;
        o_res.integ_we   = active && !refuse;
        if (!active) begin
            o_res.drive     = '0;
            o_res.saturated = 1'b0;
        end else if (y_out > lim_w) begin
            o_res.drive     = i_cfg.drive_lim;
            o_res.saturated = 1'b1;
        end else if (y_out < -lim_w) begin
            o_res.drive     = -i_cfg.drive_lim;
            o_res.saturated = 1'b1;
        end else begin
            o_res.drive     = y_out[DATA_W-1:0];
            o_res.saturated = 1'b0;
        end
    end

endmodule

// ----- rtl/pi_controller_conditional_antiwindup_unit.sv -----
// Top level: PI controller with conditional-integration anti-windup, stream in and out.
//
// Usage
//   Slave stream: one request per control sample. s_axis_tdata carries, from bit 0 up,
//   reference [15:0], feedback [31:16], feed-forward term [47:32], all Q1.15.
//   Master stream: one result per request. m_axis_tdata is drive (Q1.15), m_axis_tuser
//   is the saturated flag.
//   Config port: i_cfg_we with i_cfg_index (0 prop gain, 1 integ gain, 2 drive limit)
//   and i_cfg_data; takes effect on the next edge. Write only while no request is
//   in flight. Index 3 is ignored.
// Pipeline and throughput
//   Input register, one combinational step (two 17x32 multiplies, adds, clamps), result register;
//   the integrator feeds back within that single step. One request per cycle sustained while
//   m_axis_tready is high; the request moves from the input register into the result register.
// Reset
//   Synchronous, active low: gains to 1.0 and 0, limit to 32767, integrator to zero,
//   both stream stages emptied.
// Back-pressure
//   With m_axis_tready low the result register holds; the input register still takes one
//   more request, then s_axis_tready drops until the master side drains.
module pi_controller_conditional_antiwindup_unit
    import pcaw_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // slave stream
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0] i_s_axis_tdata,   // reference, feedback, feed-forward term
    // master stream
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [DATA_W-1:0]     o_m_axis_tdata,   // drive
    output logic                  o_m_axis_tuser,   // saturated
    // config write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg                      cfg;
    t_step_res                 step_res;

    // input stage
    logic                      r_in_valid;
    logic signed [DATA_W-1:0]  r_in_reference;
    logic signed [DATA_W-1:0]  r_in_feedback;
    logic signed [DATA_W-1:0]  r_in_ff_term;

    // state and result stage
    logic signed [INTEG_W-1:0] r_integ;
    logic                      r_out_valid;
    logic signed [DATA_W-1:0]  r_out_drive;
    logic                      r_out_sat;

    logic                      advance;
    logic                      load;
    logic                      take;

    pcaw_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    pcaw_step u_step (
        .i_cfg       (cfg),
        .i_reference (r_in_reference),
        .i_feedback  (r_in_feedback),
        .i_ff_term   (r_in_ff_term),
        .i_integ     (r_integ),
        .o_res       (step_res)
    );

    // result register free, or being drained this cycle
    assign advance         = !r_out_valid || i_m_axis_tready;
    assign load            = r_in_valid && advance;
    assign o_s_axis_tready = !r_in_valid || advance;
    assign take            = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (take) begin
            r_in_valid <= 1'b1;
        end else if (load) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_in_reference <= i_s_axis_tdata[DATA_W-1:0];
            r_in_feedback  <= i_s_axis_tdata[2*DATA_W-1:DATA_W];
            r_in_ff_term   <= i_s_axis_tdata[3*DATA_W-1:2*DATA_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ <= '0;
        end else if (load && step_res.integ_we) begin
            r_integ <= step_res.integ_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_drive <= step_res.drive;
            r_out_sat   <= step_res.saturated;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_drive;
    assign o_m_axis_tuser  = r_out_sat;

`ifndef SYNTH
    // integrator stays inside the widest possible bound
    a_integ_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_integ <= INTEG_MAX) && (r_integ >= -INTEG_MAX))
        else $error("integrator beyond 32767*65536");

    // integrator moves only when a request is processed
    a_integ_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !load |=> $stable(r_integ))
        else $error("integrator changed without a request");

    // non-positive limit forces a zero, unsaturated result
    a_zero_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && (cfg.drive_lim[DATA_W-1] || (cfg.drive_lim == '0)))
        |=> (r_out_drive == '0) && !r_out_sat)
        else $error("non-positive limit gave non-zero output");

    // a saturated result sits exactly on the limit
    a_sat_on_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_sat)
        |-> ((r_out_drive == cfg.drive_lim) || (r_out_drive == -cfg.drive_lim)))
        else $error("saturated flag set off the limit");
`endif

endmodule

// ----- verif/pi_controller_conditional_antiwindup_unit_tb.sv -----
// Self-checking stream testbench for the PI controller with conditional-integration anti-windup.
`timescale 1ns / 100ps

module pi_controller_conditional_antiwindup_unit_tb;
    import pcaw_pkg::*;

    localparam int      STALL_LIMIT  = 1000;  // quiet cycles before the run is called hung
    localparam int      TAIL_CYCLES  = 8;     // settle time after the last result
    localparam int      LONG_HOLD    = 64;    // receiver back-pressure stretch
    localparam int      RAND_PHASES  = 12;
    localparam int      PHASE_ITEMS  = 152;
    localparam int      SEGMENT_LEN  = 24;    // requests sharing one set-point and bias
    localparam int      MAX_REPORTS  = 10;
    localparam shortint Q15_MAX      = 32767;
    localparam shortint Q15_MIN      = -32768;
    localparam longint  GAIN_ONE     = 65536;  // 1.0 at 16 fractional bits
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;  // unmapped, write is dropped

    // ------------------------------------------------------------------
    // Predictor: own copy of gains, limit and integrator. One expected
    // drive per accepted request, matched in order against the output.
    // ------------------------------------------------------------------
    class t_drive_scoreboard;
        typedef struct {
            shortint drive;
            bit      saturated;
        } t_drive_rec;

        int                        prop_gain;
        int                        integ_gain;
        shortint                   drive_limit;
        logic signed [INTEG_W-1:0] integ_acc;
        t_drive_rec                pending_drives[$];
        int                        fail_count;

        function new();
            prop_gain   = PROP_GAIN_RST;
            integ_gain  = INTEG_GAIN_RST;
            drive_limit = DRIVE_LIM_RST;
            integ_acc   = '0;
            fail_count  = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_PROP_GAIN:  prop_gain   = int'(data);
                CFG_INTEG_GAIN: integ_gain  = int'(data);
                CFG_DRIVE_LIM:  drive_limit = shortint'(data[DATA_W-1:0]);
                default: ;
            endcase
        endfunction

        // one PI step; tdata is target, measured, feed-forward from bit 0 up
        function void take_request(logic [IN_TDATA_W-1:0] td);
            longint     err, prop, bound, cand, y;
            bit         refuse;
            t_drive_rec res;
            res.drive     = 0;
            res.saturated = 1'b0;
            if (drive_limit > 0) begin
                err   = longint'(shortint'(td[15:0])) - longint'(shortint'(td[31:16]));
                prop  = (err * prop_gain) / GAIN_ONE;
                bound = longint'(drive_limit) * GAIN_ONE;
                cand  = longint'(integ_acc) + err * integ_gain;
                if (cand > bound)
                    cand = bound;
                else if (cand < -bound)
                    cand = -bound;
                y = prop + cand / GAIN_ONE + longint'(shortint'(td[47:32]));
                // conditional integration: hold if the error drives further past the limit
                refuse = (y > drive_limit && err > 0) || (y < -drive_limit && err < 0);
                if (!refuse)
                    integ_acc = cand[INTEG_W-1:0];
                y = prop + longint'(integ_acc) / GAIN_ONE + longint'(shortint'(td[47:32]));
                if (y > drive_limit) begin
                    res.drive     = drive_limit;
                    res.saturated = 1'b1;
                end else if (y < -drive_limit) begin
                    res.drive     = -drive_limit;
                    res.saturated = 1'b1;
                end else begin
                    res.drive = shortint'(y);
                end
            end
            pending_drives.push_back(res);
        endfunction

        function void check_drive(logic [DATA_W-1:0] drv, logic sat);
            t_drive_rec want;
            if (pending_drives.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("unexpected result: drive %0d sat %0b", $signed(drv), sat);
            end else begin
                want = pending_drives.pop_front();
                if (drv !== want.drive || sat !== want.saturated) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("drive mismatch: expected %0d sat %0b, got %0d sat %0b",
                                 want.drive, want.saturated, $signed(drv), sat);
                end
            end
        endfunction

        function int pending();
            return pending_drives.size();
        endfunction

        // anything still outstanding at the end is a lost result
        function int close_out();
            if (pending_drives.size() != 0) begin
                $display("%0d results never arrived", pending_drives.size());
                fail_count += pending_drives.size();
            end
            return fail_count;
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset and DUT inputs, all known from time zero
    // ------------------------------------------------------------------
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic [IN_TDATA_W-1:0] s_tdata   = '0;
    logic                  m_tready  = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_PROP_GAIN;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    logic                  o_s_axis_tready;
    logic                  o_m_axis_tvalid;
    logic [DATA_W-1:0]     o_m_axis_tdata;
    logic                  o_m_axis_tuser;

    // per-phase idle probabilities (percent of requests or results preceded by a gap)
    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    bit sink_hold_req = 1'b0;  // asks the receiver for one long stall

    t_drive_scoreboard model = new();

    always #2 clk = ~clk;

    pi_controller_conditional_antiwindup_unit u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),     // target [15:0], measured [31:16], feed-forward [47:32]
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),  // drive
        .o_m_axis_tuser  (o_m_axis_tuser),  // saturated
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    // Both handshakes sampled on the rising edge, before the DUT registers update.
    // Request noted first so a same-edge result can never overtake it.
    always @(posedge clk) begin
        if (rst_n) begin
            if (s_tvalid && o_s_axis_tready)
                model.take_request(s_tdata);
            if (o_m_axis_tvalid && m_tready)
                model.check_drive(o_m_axis_tdata, o_m_axis_tuser);
        end
    end

    // idle gap before an item, drawn with the given probability, else zero
    function automatic int draw_gap(int idle_pct);
        if ($urandom_range(0, 99) < idle_pct)
            return $urandom_range(1, 17);
        return 0;
    endfunction

    function automatic int pick_idle_pct();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 20;
            2:       return 50;
            default: return 100;
        endcase
    endfunction

    function automatic shortint clip_q15(int v);
        if (v > Q15_MAX)
            return Q15_MAX;
        if (v < Q15_MIN)
            return Q15_MIN;
        return shortint'(v);
    endfunction

    function automatic shortint edge_value();
        case ($urandom_range(0, 4))
            0:       return Q15_MIN;
            1:       return -1;
            2:       return 0;
            3:       return 1;
            default: return Q15_MAX;
        endcase
    endfunction

    // gain: extremes now and then, mostly a moderate span so the loop stays
    // out of saturation long enough for the integrator to matter
    function automatic int pick_gain(int span);
        case ($urandom_range(0, 5))
            0: begin
                case ($urandom_range(0, 3))
                    0:       return int'(32'h7fff_ffff);
                    1:       return int'(32'h8000_0000);
                    2:       return 0;
                    default: return -65536;
                endcase
            end
            1:       return int'($urandom);
            default: return int'($urandom_range(0, 2 * span)) - span;
        endcase
    endfunction

    function automatic shortint pick_limit();
        case ($urandom_range(0, 11))
            0:       return Q15_MIN;
            1:       return 0;
            2:       return 1;
            3:       return Q15_MAX;
            4, 5, 6: return shortint'($urandom_range(1, 2000));
            default: return shortint'($urandom_range(1, 32767));
        endcase
    endfunction

    // Offer one request; valid stays high into the next call when no gap is drawn.
    task automatic send_request(shortint target, shortint meas, shortint ffwd);
        int gap;
        gap = draw_gap(src_idle_pct);
        if (gap > 0) begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            s_tdata  <= {16'($urandom), $urandom};  // junk while idle
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {ffwd, meas, target};
        do @(posedge clk); while (!(s_tvalid && o_s_axis_tready));
    endtask

    // Stop offering and wait for every outstanding result.
    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (model.pending() != 0)
            @(posedge clk);
    endtask

    // Register writes only with the pipeline empty.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        drain();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
        cfg_data  <= $urandom;
        model.set_register(idx, data);
    endtask

    // Random phase: mostly segments with a fixed set-point and a steady
    // error bias, so the integrator winds up, hits its bound and gets refused;
    // the rest is full-range noise and edge values.
    task automatic run_random_phase(int count);
        shortint setpt, target, meas, ffwd;
        int      bias;
        setpt = 0;
        bias  = 0;
        for (int i = 0; i < count; i++) begin
            if (i % SEGMENT_LEN == 0) begin
                setpt = shortint'($urandom);
                if ($urandom_range(0, 3) == 0)
                    bias = int'(shortint'($urandom));
                else
                    bias = int'($urandom_range(0, 4000)) - 2000;
            end
            case ($urandom_range(0, 9))
                0, 1: begin
                    target = shortint'($urandom);
                    meas   = shortint'($urandom);
                    ffwd   = shortint'($urandom);
                end
                2: begin
                    target = edge_value();
                    meas   = edge_value();
                    ffwd   = edge_value();
                end
                default: begin
                    target = clip_q15(int'(setpt) + int'($urandom_range(0, 16)) - 8);
                    meas   = clip_q15(int'(setpt) - bias + int'($urandom_range(0, 128)) - 64);
                    ffwd   = shortint'(int'($urandom_range(0, 8192)) - 4096);
                end
            endcase
            send_request(target, meas, ffwd);
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: ready drops for the drawn gap before each result. A long
    // hold, counted here, lets the sender fill the pipe and stall.
    // ------------------------------------------------------------------
    initial begin : result_sink
        int gap;
        while (!rst_n)
            @(posedge clk);
        forever begin
            if (sink_hold_req) begin
                gap           = LONG_HOLD;
                sink_hold_req = 1'b0;
            end else begin
                gap = draw_gap(sink_idle_pct);
            end
            if (gap > 0) begin
                @(negedge clk);
                m_tready <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            @(negedge clk);
            m_tready <= 1'b1;
            do @(posedge clk); while (!(o_m_axis_tvalid && m_tready));
        end
    end

    // Watchdog: too long without any handshake or register write means a hang
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if (!rst_n || cfg_we || (s_tvalid && o_s_axis_tready) ||
                (o_m_axis_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // reset gains: unit proportional, no integral action, full-scale limit
        send_request(Q15_MAX, Q15_MIN, Q15_MAX);  // hard positive saturation
        send_request(Q15_MIN, Q15_MAX, Q15_MIN);  // hard negative saturation
        send_request(0, 0, 0);
        send_request(0, 0, Q15_MIN);              // feed-forward alone below -limit
        send_request(-1, 0, 1);

        // integral only, tight limit: wind up to the bound, then get refused
        write_reg(CFG_PROP_GAIN, 0);
        write_reg(CFG_INTEG_GAIN, 32'sd16384);
        write_reg(CFG_DRIVE_LIM, 1000);
        send_request(Q15_MAX, 0, 0);
        send_request(Q15_MAX, 0, 0);
        send_request(Q15_MAX, 0, 0);
        send_request(1000, 0, 500);               // would overshoot, update held
        send_request(-2000, 0, 0);                // error reverses, unwinds
        send_request(2000, 0, -2000);

        // limit dropped under the stored integrator: clamped on the next step
        write_reg(CFG_DRIVE_LIM, 10);
        send_request(0, 0, 0);

        // zero and negative limits force a zero drive, integrator untouched
        write_reg(CFG_DRIVE_LIM, 0);
        send_request(5000, 0, 100);
        write_reg(CFG_DRIVE_LIM, {16'hffff, Q15_MIN});
        send_request(Q15_MIN, Q15_MAX, 0);
        write_reg(CFG_DRIVE_LIM, 1);
        send_request(300, 0, 0);
        write_reg(CFG_DRIVE_LIM, Q15_MAX);

        // unmapped index must be dropped; then gain extremes both ways
        write_reg(CFG_SPARE_IDX, $urandom);
        write_reg(CFG_PROP_GAIN, 32'h7fff_ffff);
        write_reg(CFG_INTEG_GAIN, 32'h8000_0000);
        send_request(Q15_MAX, Q15_MIN, 0);
        send_request(Q15_MIN, Q15_MAX, Q15_MAX);
        write_reg(CFG_PROP_GAIN, 32'h8000_0000);
        write_reg(CFG_INTEG_GAIN, 32'h7fff_ffff);
        send_request(Q15_MAX, Q15_MIN, 0);
        send_request(Q15_MIN, Q15_MAX, Q15_MAX);

        // random phases, fresh settings each time
        for (int p = 0; p < RAND_PHASES; p++) begin
            write_reg(CFG_PROP_GAIN, pick_gain(1 << 18));
            write_reg(CFG_INTEG_GAIN, pick_gain(1 << 14));
            write_reg(CFG_DRIVE_LIM, {16'($urandom), pick_limit()});
            src_idle_pct  = pick_idle_pct();
            sink_idle_pct = pick_idle_pct();
            if (p == 2) begin
                // back-pressure: sender flat out while the receiver sits idle
                src_idle_pct  = 0;
                sink_hold_req = 1'b1;
            end
            run_random_phase(PHASE_ITEMS);
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (model.close_out() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/pcaw_pkg.sv
rtl/pcaw_cfg_regs.sv
rtl/pcaw_step.sv
rtl/pi_controller_conditional_antiwindup_unit.sv
verif/pi_controller_conditional_antiwindup_unit_tb.sv
